// ===== hw/rtl/pdac_pkg.sv =====
`default_nettype none
package pdac_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int REG_W      = 48;
  localparam int GAIN_W     = 16;
  localparam int IDX_W      = 3;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_KP       = 3'd0;
  localparam logic [IDX_W-1:0] REG_KD       = 3'd1;
  localparam logic [IDX_W-1:0] REG_INERTIA0 = 3'd2;
  localparam logic [IDX_W-1:0] REG_INERTIA1 = 3'd3;
  localparam logic [IDX_W-1:0] REG_INERTIA2 = 3'd4;

  // Angle and rate errors are one bit wider than the samples.
  localparam int ERR_W   = DATA_WIDTH + 1;
  // Gain products and their sum, Q.20.
  localparam int SUM_W   = DATA_WIDTH + 18;
  // Control vector after rounding to Q.12 and saturating to CTL_W bits (at most 32).
  localparam int CTL_W   = (DATA_WIDTH + 10 > 32) ? 32 : DATA_WIDTH + 10;
  // Rate product, Q.24, and after rounding to Q.12 and saturation.
  localparam int RPROD_W = 2 * DATA_WIDTH;
  localparam int PRD_W   = (2 * DATA_WIDTH - 12 > 32) ? 32 : 2 * DATA_WIDTH - 12;
  localparam int MAX_W   = (CTL_W > PRD_W) ? CTL_W : PRD_W;
  // Torque accumulator, Q.26.
  localparam int ACC_W   = MAX_W + 18;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] angle_x;
    logic signed [DATA_WIDTH-1:0] angle_y;
    logic signed [DATA_WIDTH-1:0] angle_z;
    logic signed [DATA_WIDTH-1:0] rate_x;
    logic signed [DATA_WIDTH-1:0] rate_y;
    logic signed [DATA_WIDTH-1:0] rate_z;
    logic signed [DATA_WIDTH-1:0] target_angle_x;
    logic signed [DATA_WIDTH-1:0] target_angle_y;
    logic signed [DATA_WIDTH-1:0] target_angle_z;
    logic signed [DATA_WIDTH-1:0] target_rate_x;
    logic signed [DATA_WIDTH-1:0] target_rate_y;
    logic signed [DATA_WIDTH-1:0] target_rate_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] torque_x;
    logic signed [DATA_WIDTH-1:0] torque_y;
    logic signed [DATA_WIDTH-1:0] torque_z;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pd_attitude_control_with_compensation.sv =====
`default_nettype none
// PD attitude controller with a full inertia matrix and yaw cross-coupling
// compensation. Each request carries measured and target angles and rates
// for three axes and yields one request of three saturated Q3.12 torques.
// The datapath is a five-stage pipeline (errors, gain multiplies, control
// rounding, inertia multiplies, torque sum and saturation): a request enters
// every cycle while in_stall is low, and its torques are held in the output
// register after the last stage. A stall on the output holds the pipeline
// only as far back as it is full. Gains and inertia rows are loaded through
// cfg_en/cfg_index/cfg_data and must be written only while the block holds
// no request in flight; writes to indexes beyond the last register are ignored.
module pd_attitude_control_with_compensation import pdac_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_en,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data
);

  logic [REG_W-1:0] kp_gains;
  logic [REG_W-1:0] kd_gains;
  logic [REG_W-1:0] inertia [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gains   <= '0;
      kd_gains   <= '0;
      inertia[0] <= '0;
      inertia[1] <= '0;
      inertia[2] <= '0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_KP:       kp_gains   <= cfg_data;
        REG_KD:       kd_gains   <= cfg_data;
        REG_INERTIA0: inertia[0] <= cfg_data;
        REG_INERTIA1: inertia[1] <= cfg_data;
        REG_INERTIA2: inertia[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Elastic pipeline control: a stage takes new data when it is empty or
  // when the stage after it is moving.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !out_valid || !out_stall;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1        <= in_valid;
      if (rdy2) v2        <= v1;
      if (rdy3) v3        <= v2;
      if (rdy4) v4        <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // Stage 1: angle and rate errors.
  logic signed [ERR_W-1:0]      s1_ea [3];
  logic signed [ERR_W-1:0]      s1_er [3];
  logic signed [DATA_WIDTH-1:0] s1_rx;
  logic signed [DATA_WIDTH-1:0] s1_ry;

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_ea[0] <= ERR_W'(in_data.target_angle_x) - ERR_W'(in_data.angle_x);
      s1_ea[1] <= ERR_W'(in_data.target_angle_y) - ERR_W'(in_data.angle_y);
      s1_ea[2] <= ERR_W'(in_data.target_angle_z) - ERR_W'(in_data.angle_z);
      s1_er[0] <= ERR_W'(in_data.target_rate_x) - ERR_W'(in_data.rate_x);
      s1_er[1] <= ERR_W'(in_data.target_rate_y) - ERR_W'(in_data.rate_y);
      s1_er[2] <= ERR_W'(in_data.target_rate_z) - ERR_W'(in_data.rate_z);
      s1_rx    <= in_data.rate_x;
      s1_ry    <= in_data.rate_y;
    end
  end

  // Stage 2: gain products and the roll-pitch rate product.
  logic signed [SUM_W-1:0]   s2_pp [3];
  logic signed [SUM_W-1:0]   s2_dp [3];
  logic signed [RPROD_W-1:0] s2_rp;

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      for (int i = 0; i < 3; i++) begin
        s2_pp[i] <= $signed({1'b0, kp_gains[GAIN_W*i +: GAIN_W]}) * s1_ea[i];
        s2_dp[i] <= $signed({1'b0, kd_gains[GAIN_W*i +: GAIN_W]}) * s1_er[i];
      end
      s2_rp <= s1_ry * s1_rx;
    end
  end

  // Stage 3: round the control vector and the rate product to Q.12 and saturate them.
  logic [SUM_W-1:0]   csum  [3];
  logic [CTL_W-1:0]   ctl_d [3];
  logic [RPROD_W-1:0] prd_u;
  logic [PRD_W-1:0]   prd_d;
  logic signed [CTL_W-1:0] s3_ctl [3];
  logic signed [PRD_W-1:0] s3_prd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csum[i] = s2_pp[i] + s2_dp[i] + SUM_W'(128);
      if (&csum[i][SUM_W-1:CTL_W+7] || ~|csum[i][SUM_W-1:CTL_W+7]) begin
        ctl_d[i] = csum[i][CTL_W+7:8];
      end else begin
        ctl_d[i] = {csum[i][SUM_W-1], {(CTL_W-1){~csum[i][SUM_W-1]}}};
      end
    end
    prd_u = s2_rp + RPROD_W'(2048);
    if (&prd_u[RPROD_W-1:PRD_W+11] || ~|prd_u[RPROD_W-1:PRD_W+11]) begin
      prd_d = prd_u[PRD_W+11:12];
    end else begin
      prd_d = {prd_u[RPROD_W-1], {(PRD_W-1){~prd_u[RPROD_W-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      for (int i = 0; i < 3; i++) s3_ctl[i] <= $signed(ctl_d[i]);
      s3_prd <= $signed(prd_d);
    end
  end

  // Stage 4: inertia products and the yaw compensation product.
  logic signed [CTL_W+15:0] s4_ip [3][3];
  logic signed [PRD_W+15:0] s4_cp;

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s4_ip[i][j] <= $signed(inertia[i][GAIN_W*j +: GAIN_W]) * s3_ctl[j];
        end
      end
      s4_cp <= $signed(inertia[2][GAIN_W*2 +: GAIN_W]) * s3_prd;
    end
  end

  // Stage 5: torque sums, rounded from Q.26 to Q.12 and saturated.
  logic signed [ACC_W-1:0]   acc   [3];
  logic [ACC_W-1:0]          acc_u [3];
  logic [DATA_WIDTH-1:0]     tq    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = ACC_W'(s4_ip[i][0]) + ACC_W'(s4_ip[i][1]) + ACC_W'(s4_ip[i][2]);
      if (i == 2) acc[i] = acc[i] - ACC_W'(s4_cp);
      acc_u[i] = acc[i] + ACC_W'(8192);
      if (&acc_u[i][ACC_W-1:DATA_WIDTH+13] || ~|acc_u[i][ACC_W-1:DATA_WIDTH+13]) begin
        tq[i] = acc_u[i][DATA_WIDTH+13:14];
      end else begin
        tq[i] = {acc_u[i][ACC_W-1], {(DATA_WIDTH-1){~acc_u[i][ACC_W-1]}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && v4) begin
      out_data.torque_x <= $signed(tq[0]);
      out_data.torque_y <= $signed(tq[1]);
      out_data.torque_z <= $signed(tq[2]);
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/pd_attitude_control_with_compensation_tb.sv =====
`timescale 1ns / 1ps

module pd_attitude_control_with_compensation_tb;
  import pdac_pkg::*;

  localparam int NUM_REGS   = REG_INERTIA2 + 1;
  localparam int LATENCY    = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 3000;
  localparam int NUM_DIR    = 16;
  localparam int NUM_SETTINGS = 12;
  localparam int ITEMS_PER_SETTING = 100;
  localparam logic [IDX_W-1:0] REG_LAST = REG_INERTIA2;

  localparam logic signed [DATA_WIDTH-1:0] S_MAX  = 16'sh7FFF;
  localparam logic signed [DATA_WIDTH-1:0] S_MIN  = 16'sh8000;
  localparam logic signed [DATA_WIDTH-1:0] S_ZERO = 16'sh0000;
  localparam logic signed [DATA_WIDTH-1:0] S_LSB  = 16'sh0001;
  localparam logic signed [DATA_WIDTH-1:0] S_MLSB = -16'sh0001;
  localparam logic signed [DATA_WIDTH-1:0] S_HALF = 16'sh0800;
  localparam logic signed [DATA_WIDTH-1:0] S_ONE  = 16'sh1000;
  localparam logic signed [DATA_WIDTH-1:0] S_MONE = -16'sh1000;

  typedef logic [REG_W-1:0] coef_set_t [NUM_REGS];

  typedef enum int {CFG_AT_RESET, CFG_UNIT, CFG_HALF, CFG_NEG, CFG_EXT_POS, CFG_EXT_NEG}
    cfg_set_t;

  typedef struct {
    cfg_set_t  setting;
    in_item_t  req;
    bit        typed;
    out_item_t torque;
  } dir_row_t;

  // Rows with typed torques are the ones that follow from saturation, zero gains
  // or an identity inertia matrix; the others go through the predictor.
  dir_row_t dir_rows [NUM_DIR] = '{
    '{CFG_AT_RESET, '{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                      S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}, 1'b1, '{0, 0, 0}},
    '{CFG_AT_RESET, '{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                      S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN}, 1'b1, '{0, 0, 0}},
    '{CFG_AT_RESET, '{S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN,
                      S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX}, 1'b1, '{0, 0, 0}},
    '{CFG_UNIT, '{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                  S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}, 1'b1,
      '{32767, 32767, 32767}},
    '{CFG_UNIT, '{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                  S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN}, 1'b1,
      '{-32768, -32768, -32768}},
    '{CFG_UNIT, '{S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
                  S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO}, 1'b1, '{0, 0, 0}},
    '{CFG_UNIT, '{S_ZERO, S_ZERO, S_ZERO, S_ONE, S_ONE, S_ZERO,
                  S_ZERO, S_ZERO, S_ZERO, S_ONE, S_ONE, S_ZERO}, 1'b1, '{0, 0, -4096}},
    '{CFG_UNIT, '{S_ZERO, S_ZERO, S_ZERO, S_ONE, S_MONE, S_ZERO,
                  S_ZERO, S_ZERO, S_ZERO, S_ONE, S_MONE, S_ZERO}, 1'b1, '{0, 0, 4096}},
    '{CFG_UNIT, '{S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
                  S_LSB, S_LSB, S_LSB, S_MLSB, S_MLSB, S_MLSB}, 1'b0, '{0, 0, 0}},
    '{CFG_HALF, '{S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
                  S_LSB, S_LSB, S_LSB, S_ZERO, S_ZERO, S_ZERO}, 1'b0, '{0, 0, 0}},
    '{CFG_HALF, '{S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO,
                  S_MLSB, S_MLSB, S_MLSB, S_ZERO, S_ZERO, S_ZERO}, 1'b0, '{0, 0, 0}},
    '{CFG_HALF, '{S_ZERO, S_ZERO, S_ZERO, S_LSB, S_HALF, S_ZERO,
                  S_ZERO, S_ZERO, S_ZERO, S_LSB, S_HALF, S_ZERO}, 1'b0, '{0, 0, 0}},
    '{CFG_HALF, '{S_ZERO, S_ZERO, S_ZERO, S_MLSB, S_HALF, S_ZERO,
                  S_ZERO, S_ZERO, S_ZERO, S_MLSB, S_HALF, S_ZERO}, 1'b0, '{0, 0, 0}},
    '{CFG_NEG, '{S_MIN, S_MIN, S_MIN, S_ZERO, S_ZERO, S_ZERO,
                 S_MAX, S_MAX, S_MAX, S_ZERO, S_ZERO, S_ZERO}, 1'b0, '{0, 0, 0}},
    '{CFG_NEG, '{S_MAX, S_MAX, S_MAX, S_ZERO, S_ZERO, S_ZERO,
                 S_MIN, S_MIN, S_MIN, S_ZERO, S_ZERO, S_ZERO}, 1'b0, '{0, 0, 0}},
    '{CFG_NEG, '{S_ZERO, S_ZERO, S_ZERO, S_ONE, S_MONE, S_ZERO,
                 S_HALF, S_HALF, S_HALF, S_ZERO, S_ZERO, S_ZERO}, 1'b0, '{0, 0, 0}}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;

  // Typed expectation that travels with the request on the input channel.
  bit               req_typed = 1'b0;
  out_item_t        req_torque = '0;

  logic [REG_W-1:0] coef_regs [NUM_REGS] = '{default: '0};
  out_item_t        torque_q [$];
  int               mismatches = 0;
  int               quiet_cycles = 0;
  int               send_idle_pct = 0;
  int               rcv_idle_pct = 0;
  bit               hold_req = 1'b0;
  bit               hold_ack = 1'b0;
  int               hold_left = 0;

  pd_attitude_control_with_compensation DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  function automatic longint round_q(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint gain(input logic [IDX_W-1:0] idx, input int axis);
    return longint'(coef_regs[idx][GAIN_W*axis +: GAIN_W]);
  endfunction

  function automatic longint inertia(input int row, input int col);
    return longint'($signed(coef_regs[REG_INERTIA0 + row][GAIN_W*col +: GAIN_W]));
  endfunction

  // Torques for one request under the current gains and inertia rows.
  function automatic out_item_t torque_model(input in_item_t r);
    longint meas [3];
    longint rate [3];
    longint tang [3];
    longint trate [3];
    longint ctl [3];
    longint trq [3];
    longint prod;
    longint acc;
    out_item_t t;
    meas  = '{r.angle_x, r.angle_y, r.angle_z};
    rate  = '{r.rate_x, r.rate_y, r.rate_z};
    tang  = '{r.target_angle_x, r.target_angle_y, r.target_angle_z};
    trate = '{r.target_rate_x, r.target_rate_y, r.target_rate_z};
    for (int i = 0; i < 3; i++) begin
      ctl[i] = clamp(round_q(gain(REG_KP, i) * (tang[i] - meas[i])
                             + gain(REG_KD, i) * (trate[i] - rate[i]), 8), 32);
    end
    prod = clamp(round_q(rate[1] * rate[0], 12), 32);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        acc += inertia(i, j) * ctl[j];
      end
      // Yaw picks up the gyroscopic term from the roll and pitch rates.
      if (i == 2) begin
        acc -= inertia(2, 2) * prod;
      end
      trq[i] = clamp(round_q(acc, 14), DATA_WIDTH);
    end
    t.torque_x = DATA_WIDTH'(trq[0]);
    t.torque_y = DATA_WIDTH'(trq[1]);
    t.torque_z = DATA_WIDTH'(trq[2]);
    return t;
  endfunction

  function automatic coef_set_t named_setting(input cfg_set_t s);
    coef_set_t c;
    c = '{default: '0};
    case (s)
      CFG_UNIT: begin
        c[REG_KP]       = {3{16'hFFFF}};
        c[REG_KD]       = {3{16'hFFFF}};
        c[REG_INERTIA0] = {16'h0000, 16'h0000, 16'h4000};
        c[REG_INERTIA1] = {16'h0000, 16'h4000, 16'h0000};
        c[REG_INERTIA2] = {16'h4000, 16'h0000, 16'h0000};
      end
      CFG_HALF: begin
        c[REG_KP]       = {3{16'h0080}};
        c[REG_KD]       = {3{16'h0080}};
        c[REG_INERTIA0] = {16'h0000, 16'h0000, 16'h4000};
        c[REG_INERTIA1] = {16'h0000, 16'h4000, 16'h0000};
        c[REG_INERTIA2] = {16'h2000, 16'h0000, 16'h0000};
      end
      CFG_NEG: begin
        c[REG_KP] = {3{16'h0100}};
        for (int k = REG_INERTIA0; k <= REG_LAST; k++) c[k] = {3{16'h8000}};
      end
      CFG_EXT_POS: begin
        c[REG_KP] = {3{16'hFFFF}};
        c[REG_KD] = {3{16'hFFFF}};
        for (int k = REG_INERTIA0; k <= REG_LAST; k++) c[k] = {3{16'h7FFF}};
      end
      CFG_EXT_NEG: begin
        c[REG_KP] = {3{16'hFFFF}};
        c[REG_KD] = {3{16'hFFFF}};
        for (int k = REG_INERTIA0; k <= REG_LAST; k++) c[k] = {3{16'h8000}};
      end
      default: ;
    endcase
    return c;
  endfunction

  // Mild settings keep the torques mostly out of saturation; the others mix
  // field extremes with fully random values.
  function automatic coef_set_t rand_setting(input bit mild);
    coef_set_t c;
    logic [GAIN_W-1:0] f;
    for (int k = 0; k < NUM_REGS; k++) begin
      for (int a = 0; a < 3; a++) begin
        if (mild) begin
          if (k == REG_KP || k == REG_KD) f = GAIN_W'($urandom_range(0, 16'h0400));
          else f = GAIN_W'($urandom_range(0, 16'h8000) - 16'h4000);
        end else begin
          case ($urandom_range(0, 5))
            0: f = 16'h0000;
            1: f = 16'hFFFF;
            2: f = 16'h7FFF;
            3: f = 16'h8000;
            default: f = GAIN_W'($urandom());
          endcase
        end
        c[k][GAIN_W*a +: GAIN_W] = f;
      end
    end
    return c;
  endfunction

  function automatic in_item_t rand_request();
    logic [DATA_WIDTH-1:0] f [12];
    in_item_t r;
    if ($urandom_range(0, 9) < 6) begin
      // Measurements near their targets, as in closed-loop operation.
      for (int k = 0; k < 6; k++) begin
        f[k]     = DATA_WIDTH'($urandom_range(0, 16'h7FFF) - 16'h4000);
        f[k + 6] = f[k] + DATA_WIDTH'($urandom_range(0, 2047) - 1024);
      end
    end else begin
      for (int k = 0; k < 12; k++) begin
        case ($urandom_range(0, 7))
          0: f[k] = S_MAX;
          1: f[k] = S_MIN;
          2: f[k] = S_ZERO;
          default: f[k] = DATA_WIDTH'($urandom());
        endcase
      end
    end
    for (int k = 0; k < 12; k++) r[(11 - k)*DATA_WIDTH +: DATA_WIDTH] = f[k];
    return r;
  endfunction

  task automatic send_request(input in_item_t req, input bit typed, input out_item_t torque);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= req;
    req_typed  <= typed;
    req_torque <= torque;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (torque_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic apply_setting(input coef_set_t c, input bit poke_unused);
    for (int k = 0; k < NUM_REGS; k++) begin
      cfg_en    <= 1'b1;
      cfg_index <= IDX_W'(k);
      cfg_data  <= c[k];
      coef_regs[k] = c[k];
      @(posedge clk);
    end
    // Indexes past the last register must leave every register untouched.
    if (poke_unused) begin
      for (int k = REG_LAST + 1; k < 2**IDX_W; k++) begin
        cfg_en    <= 1'b1;
        cfg_index <= IDX_W'(k);
        cfg_data  <= '0;
        @(posedge clk);
      end
    end
    cfg_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [DATA_WIDTH-1:0] want,
                             input logic signed [DATA_WIDTH-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_ack) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_ack  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        torque_q.push_back(req_typed ? req_torque : torque_model(in_data));
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (torque_q.size() == 0) begin
          $error("torque request with no expectation waiting");
          mismatches++;
        end else begin
          want = torque_q.pop_front();
          check_field("torque_x", want.torque_x, out_data.torque_x);
          check_field("torque_y", want.torque_y, out_data.torque_y);
          check_field("torque_z", want.torque_z, out_data.torque_z);
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("pd_attitude_control_with_compensation test failed");
        $finish;
      end
    end
  end

  initial begin
    cfg_set_t  cur;
    coef_set_t c;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 24;
    rcv_idle_pct  = 55;
    cur = CFG_AT_RESET;
    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_rows[i].setting != cur) begin
        drain();
        cur = dir_rows[i].setting;
        apply_setting(named_setting(cur), cur == CFG_UNIT);
      end
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].torque);
    end

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      drain();
      case (s)
        0: c = named_setting(CFG_EXT_POS);
        1: c = named_setting(CFG_EXT_NEG);
        default: c = rand_setting(s % 2 == 0);
      endcase
      apply_setting(c, 1'b0);
      send_idle_pct = (s < 4) ? 24 : ((s < 8) ? 55 : 0);
      rcv_idle_pct  = (s < 4) ? 55 : ((s < 8) ? 24 : 0);
      if (s == 8) begin
        // Long output hold-off with the input kept busy to back up the pipeline.
        hold_req <= 1'b1;
        @(posedge clk);
        while (!hold_ack) @(posedge clk);
        hold_req <= 1'b0;
      end
      repeat (ITEMS_PER_SETTING) send_request(rand_request(), 1'b0, '0);
    end

    drain();
    if (mismatches == 0) begin
      $display("pd_attitude_control_with_compensation test passed");
    end else begin
      $display("pd_attitude_control_with_compensation test failed");
    end
    $finish;
  end

endmodule
